@@ rtl/ocas_pkg.sv @@
// shared types and constants for the object conflict admission scheduler
// no dependencies
package ocas_pkg;

  localparam int QUEUE_DEPTH_D = 16;
  localparam int NUM_TX_D      = 16;
  localparam int NUM_OBJECTS_D = 64;

  localparam int TX_W   = 4;
  localparam int MASK_W = 64;
  localparam int KEY_W  = 62;
  localparam int PRIO_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_COMMIT  = 1'b1;

  localparam logic [1:0] VD_GRANTED  = 2'd0;
  localparam logic [1:0] VD_WAITING  = 2'd1;
  localparam logic [1:0] VD_COMMIT   = 2'd2;
  localparam logic [1:0] VD_REJECTED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRANTED_PRIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAITING_PRIO = 2'd1;

  typedef enum logic [1:0] {
    PH_RELEASED  = 2'd0,
    PH_EXECUTING = 2'd1,
    PH_WAITING   = 2'd2
  } phase_t;

  typedef struct packed {
    logic              op;
    logic [TX_W-1:0]   tx_id;
    logic [MASK_W-1:0] obj_mask;
    logic [31:0]       deadline_sec;
    logic [29:0]       deadline_nsec;
  } in_t;

  typedef struct packed {
    logic [TX_W-1:0]   out_tx_id;
    logic [1:0]        verdict;
    logic [PRIO_W-1:0] priority_res;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [TX_W-1:0]   tx;
    logic [MASK_W-1:0] mask;
    logic [KEY_W-1:0]  key;
  } qent_t;

  // broadcast to every queue cell
  typedef struct packed {
    logic  ins;
    logic  rm_id;
    logic  rm_at;
    qent_t ent;
  } qctl_t;

endpackage

@@ rtl/ocas_cell.sv @@
// one queue slot: holds an entry, shifts toward tail on insert, toward head on removal
// depends on ocas_pkg
module ocas_cell import ocas_pkg::*; #(
  parameter int IDX   = 0,
  parameter int DEPTH = QUEUE_DEPTH_D
) (
  input  logic                          clk,
  input  qctl_t                         ctl,
  input  logic [$clog2(DEPTH+1)-1:0]    cnt,
  input  logic [$clog2(DEPTH+1)-1:0]    at_idx,
  input  logic                          l_gt,
  input  logic                          l_valid,
  input  qent_t                         l_ent,
  input  qent_t                         r_ent,
  input  logic                          del_in,
  output logic                          valid,
  output logic                          gt,
  output logic                          del_out,
  output qent_t                         ent
);

  localparam int CW = $clog2(DEPTH+1);

  qent_t ent_r, ent_nxt;
  logic  hit;

  assign valid   = CW'(IDX) < cnt;
  assign gt      = valid && (ent_r.key > ctl.ent.key);
  assign hit     = valid && ((ctl.rm_id && ent_r.tx == ctl.ent.tx) ||
                             (ctl.rm_at && at_idx == CW'(IDX)));
  assign del_out = del_in | hit;
  assign ent     = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (l_gt) begin
        ent_nxt = l_ent;
      end else if (gt || (!valid && l_valid)) begin
        ent_nxt = ctl.ent;
      end
    end else if ((ctl.rm_id || ctl.rm_at) && del_out) begin
      ent_nxt = r_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ rtl/object_conflict_admission_scheduler.sv @@
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | in_data (in_t)
// out     | out | out_valid/out_ready| out_data (out_t)
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a release or a waiting commit: result goes to the pending register, then to the output
// register in the flush state once the output is free; next request taken back in idle
// a freeing commit walks the deadline queue one slot a cycle, skip or grant, a grant
// waiting while the output stalls; then the flush state registers the last result, to idle
// rst_n synchronous: held set, queue count and phases cleared, priority registers to defaults
// output stalls hold a grant in the scan; the next request waits for the last result to register
// top level: control, held set, phases and the chain of queue cells
// depends on ocas_pkg and ocas_cell
module object_conflict_admission_scheduler import ocas_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D,
  parameter int NUM_TX      = NUM_TX_D,
  parameter int NUM_OBJECTS = NUM_OBJECTS_D
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PRIO_W-1:0]    cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH+1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [MASK_W-1:0] OBJ_ALL = {MASK_W{1'b1}} >> (MASK_W - NUM_OBJECTS);
  localparam int NID = 1 << TX_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [MASK_W-1:0] held_r, held_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  phase_t            phase_r [NID];
  phase_t            phase_nxt [NID];
  logic [PRIO_W-1:0] gprio_r, wprio_r;
  out_t              out_r, out_nxt, pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;

  qctl_t ctl;
  logic  c_valid [QUEUE_DEPTH];
  logic  c_gt    [QUEUE_DEPTH];
  logic  c_del   [QUEUE_DEPTH];
  qent_t c_ent   [QUEUE_DEPTH];

  logic              accept, out_free, id_ok;
  logic [MASK_W-1:0] m;
  qent_t             sel;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign id_ok     = int'(in_data.tx_id) < NUM_TX;
  assign m         = in_data.obj_mask & OBJ_ALL;
  assign sel       = c_ent[scan_r[IW-1:0]];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      ocas_cell #(.IDX(gi), .DEPTH(QUEUE_DEPTH)) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .cnt     (cnt_r),
        .at_idx  (scan_r),
        .l_gt    ((gi == 0) ? 1'b0 : c_gt[(gi == 0) ? 0 : gi-1]),
        .l_valid ((gi == 0) ? 1'b1 : c_valid[(gi == 0) ? 0 : gi-1]),
        .l_ent   (c_ent[(gi == 0) ? 0 : gi-1]),
        .r_ent   (c_ent[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
        .del_in  ((gi == 0) ? 1'b0 : c_del[(gi == 0) ? 0 : gi-1]),
        .valid   (c_valid[gi]),
        .gt      (c_gt[gi]),
        .del_out (c_del[gi]),
        .ent     (c_ent[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    scan_nxt  = scan_r;
    phase_nxt = phase_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_ready;
    pend_nxt  = pend_r;
    ctl.ins   = 1'b0;
    ctl.rm_id = 1'b0;
    ctl.rm_at = 1'b0;
    ctl.ent.tx   = in_data.tx_id;
    ctl.ent.mask = m;
    ctl.ent.key  = {in_data.deadline_sec, in_data.deadline_nsec};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pend_nxt.out_tx_id    = in_data.tx_id;
          pend_nxt.priority_res = '0;
          pend_nxt.last         = 1'b0;
          state_nxt             = ST_FLUSH;
          if (in_data.op == OP_RELEASE) begin
            if (!id_ok || phase_r[in_data.tx_id] != PH_RELEASED) begin
              pend_nxt.verdict = VD_REJECTED;
            end else if ((held_r & m) != '0) begin
              if (int'(cnt_r) >= QUEUE_DEPTH) begin
                pend_nxt.verdict = VD_REJECTED;
              end else begin
                ctl.ins                   = 1'b1;
                cnt_nxt                   = cnt_r + 1'b1;
                phase_nxt[in_data.tx_id]  = PH_WAITING;
                pend_nxt.verdict          = VD_WAITING;
                pend_nxt.priority_res     = wprio_r;
              end
            end else begin
              held_nxt                 = held_r | m;
              phase_nxt[in_data.tx_id] = PH_EXECUTING;
              pend_nxt.verdict         = VD_GRANTED;
              pend_nxt.priority_res    = gprio_r;
            end
          end else begin
            pend_nxt.verdict = VD_COMMIT;
            if (id_ok) begin
              phase_nxt[in_data.tx_id] = PH_RELEASED;
              if (phase_r[in_data.tx_id] == PH_WAITING) begin
                // waiting entry leaves the chain, later slots close the gap
                ctl.rm_id = 1'b1;
                cnt_nxt   = cnt_r - 1'b1;
              end else begin
                held_nxt  = held_r & ~m;
                scan_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_r >= cnt_r) begin
          state_nxt = ST_FLUSH;
        end else if ((held_r & sel.mask) != '0) begin
          scan_nxt = scan_r + 1'b1;
        end else if (out_free) begin
          // previous result is not the last one, grant becomes the new pending
          out_nxt               = pend_r;
          out_nxt.last          = 1'b0;
          out_v_nxt             = 1'b1;
          pend_nxt.out_tx_id    = sel.tx;
          pend_nxt.verdict      = VD_GRANTED;
          pend_nxt.priority_res = gprio_r;
          pend_nxt.last         = 1'b0;
          held_nxt              = held_r | sel.mask;
          phase_nxt[sel.tx]     = PH_EXECUTING;
          ctl.rm_at             = 1'b1;
          cnt_nxt               = cnt_r - 1'b1;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      cnt_r   <= '0;
      scan_r  <= '0;
      out_v_r <= 1'b0;
      gprio_r <= 7'd99;
      wprio_r <= 7'd1;
      for (int i = 0; i < NID; i++) begin
        phase_r[i] <= PH_RELEASED;
      end
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
      scan_r  <= scan_nxt;
      out_v_r <= out_v_nxt;
      phase_r <= phase_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRANTED_PRIO) begin
          gprio_r <= cfg_data;
        end else if (cfg_index == REG_WAITING_PRIO) begin
          wprio_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= QUEUE_DEPTH)
    else $error("queue count above depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_r <= cnt_r)
    else $error("scan index past queue tail");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH && out_free |=> out_v_r && out_r.last && state_r == ST_IDLE)
    else $error("final result not marked last");

endmodule
